>>> hw/rtl/ial_pkg.sv
// Shared types and constants for the indentation-aware lexer.
// Used by ial_ctrl, ial_dp and the top level; depends on nothing.
`default_nettype none
package ial_pkg;

  localparam int TAB_WIDTH_DEF   = 8;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 20;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;

  typedef enum logic [3:0] {
    K_INDENT   = 4'd0,
    K_DEDENT   = 4'd1,
    K_WSTART   = 4'd2,
    K_WBYTE    = 4'd3,
    K_WEND     = 4'd4,
    K_SSTART   = 4'd5,
    K_SBYTE    = 4'd6,
    K_SEND     = 4'd7,
    K_NEWLINE  = 4'd8,
    K_EOF      = 4'd9,
    K_BADDED   = 4'd10,
    K_OPENSTR  = 4'd11,
    K_OVERFLOW = 4'd12
  } kind_e;

  typedef enum logic [2:0] {
    M_INDENT, M_BETWEEN, M_WORD, M_STRING, M_ESCAPE, M_COMMENT
  } mode_e;

  typedef enum logic [1:0] {COL_NOW, COL_EV, COL_TOK, COL_ONE} col_sel_e;
  typedef enum logic [1:0] {BV_ZERO, BV_CUR, BV_ESC} byte_sel_e;

  typedef struct packed {
    logic      latch;
    logic      cur_cr;
    logic      cur_byte;
    logic      col_step;
    logic      ws_space;
    logic      ws_tab;
    logic      mode_we;
    mode_e     mode;
    logic      set_content;
    logic      set_tokcol;
    logic      push;
    logic      pop;
    logic      load_top;
    logic      next_line;
    logic      set_halt;
    logic      set_pcr;
    logic      clr_pcr;
    logic      emit;
    kind_e     kind;
    byte_sel_e bsel;
    col_sel_e  csel;
    logic      eline;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  is_space;
    logic  is_tab;
    logic  is_hash;
    logic  is_quote;
    logic  is_bsl;
    logic  is_cr;
    logic  is_lf;
    logic  eos;
    logic  halted;
    logic  pcr;
    logic  wider;
    logic  narrower;
    logic  top_zero;
    logic  top_full;
    logic  has_content;
    logic  can_move;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/ial_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ial_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/ial_dp.sv
// Lexer datapath: line/column counters, indent measure, stack top, event buffer.
// Depends on ial_pkg; driven by ial_ctrl, talks to the stack RAM.
`default_nettype none
module ial_dp #(
  parameter int TAB_WIDTH   = ial_pkg::TAB_WIDTH_DEF,
  parameter int STACK_DEPTH = ial_pkg::STACK_DEPTH_DEF,
  localparam int IW         = $clog2(STACK_DEPTH),
  localparam int TPW        = $clog2(TAB_WIDTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      source_byte_i,
  input  wire logic            end_of_source_i,
  input  wire ial_pkg::cmd_t   cmd_i,
  output ial_pkg::sts_t        sts_o,
  output logic                 ram_we_o,
  output logic [IW-1:0]        ram_waddr_o,
  output logic [7:0]           ram_wdata_o,
  output logic [IW-1:0]        ram_raddr_o,
  input  wire logic [7:0]      ram_rdata_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [3:0]           kind_o,
  output logic [7:0]           byte_value_o,
  output logic [23:0]          line_number_o,
  output logic [15:0]          column_o,
  output logic                 last_o
);

  logic [7:0]           byte_q, cur_q;
  logic                 eos_q;
  logic [23:0]          line_q, line_d;
  logic [15:0]          cnt_q, cnt_d;
  logic [7:0]           width_q, width_d;
  logic [TPW-1:0]       tpos_q, tpos_d;
  ial_pkg::mode_e       mode_q, mode_d;
  logic [15:0]          tok_q, tok_d, evcol_q, evcol_d;
  logic                 content_q, content_d, pcr_q, pcr_d, halt_q, halt_d;
  logic [IW-1:0]        top_q, top_d;
  logic [7:0]           topval_q, topval_d;

  logic [15:0]          col_now;
  logic [23:0]          eline;
  logic [8:0]           tab_sum;
  logic [7:0]           esc_byte;

  // event buffer: hold one event back so the final one can carry last
  logic                 hold_v_q, out_v_q;
  logic [ial_pkg::CNT_W-1:0] cnt_ev_q;
  logic [3:0]           hold_kind_q;
  logic [7:0]           hold_byte_q;
  logic [23:0]          hold_line_q;
  logic [15:0]          hold_col_q;
  logic [7:0]           ev_byte;
  logic [23:0]          ev_line;
  logic [15:0]          ev_col;
  logic                 do_emit, move_hold;

  assign col_now = (cnt_q == ial_pkg::COL_MAX) ? ial_pkg::COL_MAX : cnt_q + 16'd1;
  assign eline   = (line_q == ial_pkg::LINE_MAX) ? ial_pkg::LINE_MAX : line_q + 24'd1;
  assign tab_sum = {1'b0, width_q} + (9'(TAB_WIDTH) - 9'(tpos_q));

  always_comb begin
    unique case (cur_q)
      ial_pkg::CH_N: esc_byte = ial_pkg::CH_LF;
      ial_pkg::CH_T: esc_byte = ial_pkg::CH_TAB;
      ial_pkg::CH_R: esc_byte = ial_pkg::CH_CR;
      default:       esc_byte = cur_q;
    endcase
  end

  always_comb begin
    line_d    = line_q;
    cnt_d     = cnt_q;
    width_d   = width_q;
    tpos_d    = tpos_q;
    mode_d    = mode_q;
    tok_d     = tok_q;
    evcol_d   = evcol_q;
    content_d = content_q;
    pcr_d     = pcr_q;
    halt_d    = halt_q;
    top_d     = top_q;
    topval_d  = topval_q;
    if (cmd_i.col_step) begin
      evcol_d = col_now;
      if (cnt_q != ial_pkg::COL_MAX) cnt_d = cnt_q + 16'd1;
    end
    if (cmd_i.ws_space) begin
      if (width_q != 8'd255) width_d = width_q + 8'd1;
      tpos_d = (32'(tpos_q) + 1 == TAB_WIDTH) ? '0 : tpos_q + TPW'(1);
    end
    if (cmd_i.ws_tab) begin
      width_d = (tab_sum > 9'd255) ? 8'd255 : tab_sum[7:0];
      tpos_d  = '0;
    end
    if (cmd_i.mode_we) mode_d = cmd_i.mode;
    if (cmd_i.set_tokcol) tok_d = evcol_q;
    if (cmd_i.set_content) content_d = 1'b1;
    if (cmd_i.push) begin
      top_d    = top_q + IW'(1);
      topval_d = width_q;
    end
    if (cmd_i.pop) top_d = top_q - IW'(1);
    if (cmd_i.load_top) topval_d = (top_q == '0) ? 8'd0 : ram_rdata_i;
    if (cmd_i.set_halt) halt_d = 1'b1;
    if (cmd_i.set_pcr) pcr_d = 1'b1;
    if (cmd_i.clr_pcr) pcr_d = 1'b0;
    if (cmd_i.next_line) begin
      line_d    = eline;
      cnt_d     = '0;
      width_d   = '0;
      tpos_d    = '0;
      mode_d    = ial_pkg::M_INDENT;
      content_d = 1'b0;
      tok_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q    <= 24'd1;
      cnt_q     <= '0;
      width_q   <= '0;
      tpos_q    <= '0;
      mode_q    <= ial_pkg::M_INDENT;
      tok_q     <= '0;
      evcol_q   <= '0;
      content_q <= 1'b0;
      pcr_q     <= 1'b0;
      halt_q    <= 1'b0;
      top_q     <= '0;
      topval_q  <= '0;
    end else begin
      line_q    <= line_d;
      cnt_q     <= cnt_d;
      width_q   <= width_d;
      tpos_q    <= tpos_d;
      mode_q    <= mode_d;
      tok_q     <= tok_d;
      evcol_q   <= evcol_d;
      content_q <= content_d;
      pcr_q     <= pcr_d;
      halt_q    <= halt_d;
      top_q     <= top_d;
      topval_q  <= topval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= source_byte_i;
      cur_q  <= source_byte_i;
      eos_q  <= end_of_source_i;
    end else if (cmd_i.cur_cr) begin
      cur_q <= ial_pkg::CH_CR;
    end else if (cmd_i.cur_byte) begin
      cur_q <= byte_q;
    end
  end

  assign ram_we_o    = cmd_i.push;
  assign ram_waddr_o = top_q + IW'(1);
  assign ram_wdata_o = width_q;
  assign ram_raddr_o = top_d;

  assign sts_o.mode        = mode_q;
  assign sts_o.is_space    = cur_q == ial_pkg::CH_SPACE;
  assign sts_o.is_tab      = cur_q == ial_pkg::CH_TAB;
  assign sts_o.is_hash     = cur_q == ial_pkg::CH_HASH;
  assign sts_o.is_quote    = cur_q == ial_pkg::CH_QUOTE;
  assign sts_o.is_bsl      = cur_q == ial_pkg::CH_BSL;
  assign sts_o.is_cr       = cur_q == ial_pkg::CH_CR;
  assign sts_o.is_lf       = cur_q == ial_pkg::CH_LF;
  assign sts_o.eos         = eos_q;
  assign sts_o.halted      = halt_q;
  assign sts_o.pcr         = pcr_q;
  assign sts_o.wider       = width_q > topval_q;
  assign sts_o.narrower    = width_q < topval_q;
  assign sts_o.top_zero    = top_q == '0;
  assign sts_o.top_full    = 32'(top_q) == STACK_DEPTH - 1;
  assign sts_o.has_content = content_q;
  assign sts_o.can_move    = !out_v_q || out_ready_i;

  always_comb begin
    unique case (cmd_i.bsel)
      ial_pkg::BV_CUR: ev_byte = cur_q;
      ial_pkg::BV_ESC: ev_byte = esc_byte;
      default:         ev_byte = 8'd0;
    endcase
    unique case (cmd_i.csel)
      ial_pkg::COL_NOW: ev_col = col_now;
      ial_pkg::COL_EV:  ev_col = evcol_q;
      ial_pkg::COL_TOK: ev_col = tok_q;
      default:          ev_col = 16'd1;
    endcase
    ev_line = cmd_i.eline ? eline : line_q;
  end

  // drop events beyond the per-item bound
  assign do_emit   = cmd_i.emit && (cnt_ev_q < ial_pkg::CNT_W'(ial_pkg::MAX_RESULTS));
  assign move_hold = hold_v_q && (do_emit || cmd_i.finish);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      cnt_ev_q <= '0;
    end else begin
      if (move_hold) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        hold_v_q <= 1'b0;
        cnt_ev_q <= '0;
      end else if (do_emit) begin
        hold_v_q <= 1'b1;
        cnt_ev_q <= cnt_ev_q + ial_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_hold) begin
      kind_o        <= hold_kind_q;
      byte_value_o  <= hold_byte_q;
      line_number_o <= hold_line_q;
      column_o      <= hold_col_q;
      last_o        <= cmd_i.finish;
    end
    if (do_emit) begin
      hold_kind_q <= cmd_i.kind;
      hold_byte_q <= ev_byte;
      hold_line_q <= ev_line;
      hold_col_q  <= ev_col;
    end
  end

  assign out_valid_o = out_v_q;

endmodule
`default_nettype wire

>>> hw/rtl/ial_ctrl.sv
// Lexer sequencer: walks one source item through its steps, at most one event
// a cycle while the output can move. Depends on ial_pkg; commands ial_dp.
`default_nettype none
module ial_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ial_pkg::sts_t sts_i,
  output ial_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RELOAD, S_TAKE, S_BYTE, S_POP, S_POPW, S_START,
    S_WBYTE, S_CLOSE, S_CLOSE2, S_EOSPOP, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   follow_q, follow_d;
  state_e done_state;

  assign done_state = follow_q ? S_RELOAD : S_FIN;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    follow_d = follow_q;
    if (state_q == S_IDLE) begin
      if (in_valid_i) begin
        cmd_o.latch = 1'b1;
        state_d     = S_DISP;
      end
    end else if (sts_i.can_move) begin
      unique case (state_q)
        S_DISP: begin
          if (sts_i.halted) begin
            state_d = S_IDLE;
          end else if (sts_i.eos) begin
            cmd_o.clr_pcr = 1'b1;
            state_d       = S_CLOSE;
          end else if (sts_i.pcr) begin
            cmd_o.clr_pcr = 1'b1;
            if (sts_i.is_lf) begin
              state_d = S_CLOSE;
            end else begin
              // the held CR is content; the new byte follows it
              cmd_o.cur_cr = 1'b1;
              follow_d     = 1'b1;
              state_d      = S_BYTE;
            end
          end else begin
            state_d = S_TAKE;
          end
        end
        S_RELOAD: begin
          cmd_o.cur_byte = 1'b1;
          follow_d       = 1'b0;
          state_d        = S_TAKE;
        end
        S_TAKE: begin
          if (sts_i.is_cr) begin
            cmd_o.set_pcr = 1'b1;
            state_d       = S_FIN;
          end else if (sts_i.is_lf) begin
            state_d = S_CLOSE;
          end else begin
            state_d = S_BYTE;
          end
        end
        S_BYTE: begin
          cmd_o.col_step = 1'b1;
          state_d        = done_state;
          unique case (sts_i.mode)
            ial_pkg::M_INDENT: begin
              if (sts_i.is_space) begin
                cmd_o.ws_space = 1'b1;
              end else if (sts_i.is_tab) begin
                cmd_o.ws_tab = 1'b1;
              end else if (sts_i.is_hash) begin
                cmd_o.mode_we = 1'b1;
                cmd_o.mode    = ial_pkg::M_COMMENT;
              end else begin
                cmd_o.set_content = 1'b1;
                if (sts_i.wider) begin
                  cmd_o.emit = 1'b1;
                  cmd_o.csel = ial_pkg::COL_NOW;
                  if (sts_i.top_full) begin
                    cmd_o.kind     = ial_pkg::K_OVERFLOW;
                    cmd_o.set_halt = 1'b1;
                    state_d        = S_FIN;
                  end else begin
                    cmd_o.kind = ial_pkg::K_INDENT;
                    cmd_o.push = 1'b1;
                    state_d    = S_START;
                  end
                end else if (sts_i.narrower) begin
                  state_d = S_POP;
                end else begin
                  state_d = S_START;
                end
              end
            end
            ial_pkg::M_BETWEEN: begin
              if (!sts_i.is_space && !sts_i.is_tab) state_d = S_START;
            end
            ial_pkg::M_WORD: begin
              cmd_o.emit = 1'b1;
              cmd_o.csel = ial_pkg::COL_TOK;
              if (sts_i.is_space || sts_i.is_tab) begin
                cmd_o.kind    = ial_pkg::K_WEND;
                cmd_o.mode_we = 1'b1;
                cmd_o.mode    = ial_pkg::M_BETWEEN;
              end else begin
                cmd_o.kind = ial_pkg::K_WBYTE;
                cmd_o.bsel = ial_pkg::BV_CUR;
              end
            end
            ial_pkg::M_STRING: begin
              if (sts_i.is_bsl) begin
                cmd_o.mode_we = 1'b1;
                cmd_o.mode    = ial_pkg::M_ESCAPE;
              end else if (sts_i.is_quote) begin
                cmd_o.emit    = 1'b1;
                cmd_o.kind    = ial_pkg::K_SEND;
                cmd_o.csel    = ial_pkg::COL_TOK;
                cmd_o.mode_we = 1'b1;
                cmd_o.mode    = ial_pkg::M_BETWEEN;
              end else begin
                cmd_o.emit = 1'b1;
                cmd_o.kind = ial_pkg::K_SBYTE;
                cmd_o.bsel = ial_pkg::BV_CUR;
                cmd_o.csel = ial_pkg::COL_TOK;
              end
            end
            ial_pkg::M_ESCAPE: begin
              cmd_o.emit    = 1'b1;
              cmd_o.kind    = ial_pkg::K_SBYTE;
              cmd_o.bsel    = ial_pkg::BV_ESC;
              cmd_o.csel    = ial_pkg::COL_TOK;
              cmd_o.mode_we = 1'b1;
              cmd_o.mode    = ial_pkg::M_STRING;
            end
            default: ;
          endcase
        end
        S_POP: begin
          if (sts_i.narrower && !sts_i.top_zero) begin
            cmd_o.pop  = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.kind = ial_pkg::K_DEDENT;
            cmd_o.csel = ial_pkg::COL_EV;
            state_d    = S_POPW;
          end else if (sts_i.narrower || sts_i.wider) begin
            cmd_o.emit     = 1'b1;
            cmd_o.kind     = ial_pkg::K_BADDED;
            cmd_o.csel     = ial_pkg::COL_EV;
            cmd_o.set_halt = 1'b1;
            state_d        = S_FIN;
          end else begin
            state_d = S_START;
          end
        end
        S_POPW: begin
          cmd_o.load_top = 1'b1;
          state_d        = S_POP;
        end
        S_START: begin
          cmd_o.mode_we = 1'b1;
          state_d       = done_state;
          if (sts_i.is_hash) begin
            cmd_o.mode = ial_pkg::M_COMMENT;
          end else if (sts_i.is_quote) begin
            cmd_o.mode       = ial_pkg::M_STRING;
            cmd_o.set_tokcol = 1'b1;
            cmd_o.emit       = 1'b1;
            cmd_o.kind       = ial_pkg::K_SSTART;
            cmd_o.csel       = ial_pkg::COL_EV;
          end else begin
            cmd_o.mode       = ial_pkg::M_WORD;
            cmd_o.set_tokcol = 1'b1;
            cmd_o.emit       = 1'b1;
            cmd_o.kind       = ial_pkg::K_WSTART;
            cmd_o.csel       = ial_pkg::COL_EV;
            state_d          = S_WBYTE;
          end
        end
        S_WBYTE: begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = ial_pkg::K_WBYTE;
          cmd_o.bsel = ial_pkg::BV_CUR;
          cmd_o.csel = ial_pkg::COL_EV;
          state_d    = done_state;
        end
        S_CLOSE: begin
          if (sts_i.mode == ial_pkg::M_WORD) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = ial_pkg::K_WEND;
            cmd_o.csel = ial_pkg::COL_TOK;
            state_d    = S_CLOSE2;
          end else if (sts_i.mode == ial_pkg::M_STRING ||
                       sts_i.mode == ial_pkg::M_ESCAPE) begin
            cmd_o.emit     = 1'b1;
            cmd_o.kind     = ial_pkg::K_OPENSTR;
            cmd_o.csel     = ial_pkg::COL_TOK;
            cmd_o.set_halt = 1'b1;
            state_d        = S_FIN;
          end else begin
            state_d = S_CLOSE2;
          end
        end
        S_CLOSE2: begin
          if (sts_i.has_content) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = ial_pkg::K_NEWLINE;
            cmd_o.csel = ial_pkg::COL_NOW;
          end
          if (sts_i.eos) begin
            state_d = S_EOSPOP;
          end else begin
            cmd_o.next_line = 1'b1;
            state_d         = S_FIN;
          end
        end
        S_EOSPOP: begin
          cmd_o.emit  = 1'b1;
          cmd_o.csel  = ial_pkg::COL_ONE;
          cmd_o.eline = 1'b1;
          if (!sts_i.top_zero) begin
            cmd_o.kind = ial_pkg::K_DEDENT;
            cmd_o.pop  = 1'b1;
          end else begin
            cmd_o.kind     = ial_pkg::K_EOF;
            cmd_o.set_halt = 1'b1;
            state_d        = S_FIN;
          end
        end
        S_FIN: begin
          cmd_o.finish = 1'b1;
          follow_d     = 1'b0;
          state_d      = S_IDLE;
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      follow_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      follow_q <= follow_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/indentation_aware_lexer_top.sv
// Top level of the indentation-aware lexer: sequencer, datapath and indent stack RAM.
// Depends on ial_pkg, ial_ram, ial_dp and ial_ctrl.
//
// Takes one source byte (or an end-of-source mark) per input transfer and
// streams token events, one per output transfer, with last set on the final
// event of each input. Inputs are handled one at a time. An ordinary byte goes
// through accept, dispatch, classify, step and finish before the next input
// transfer; a line end goes through close and newline steps in place of the
// step. Opening a word adds a start and a word-byte step, and opening a string
// a start step. A dedent burst adds a pop and a wait step per level, since each
// pop waits for the stack RAM's registered read of the new top, plus a final
// compare. A carriage return held back and then found to be content costs its
// own step plus a step to reload the byte that follows it. End of source adds
// a dedent step per open level before EOF. A stalled output stalls the sequencer.
`default_nettype none
module indentation_aware_lexer_top #(
  parameter int TAB_WIDTH   = ial_pkg::TAB_WIDTH_DEF,
  parameter int STACK_DEPTH = ial_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  source_byte_i,
  input  wire logic        end_of_source_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       kind_o,
  output logic [7:0]       byte_value_o,
  output logic [23:0]      line_number_o,
  output logic [15:0]      column_o,
  output logic             last_o
);

  localparam int IW = $clog2(STACK_DEPTH);

  ial_pkg::cmd_t cmd;
  ial_pkg::sts_t sts;
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  ial_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ial_dp #(
    .TAB_WIDTH   (TAB_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .source_byte_i   (source_byte_i),
    .end_of_source_i (end_of_source_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .byte_value_o    (byte_value_o),
    .line_number_o   (line_number_o),
    .column_o        (column_o),
    .last_o          (last_o)
  );

  ial_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
